### src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// types and constants shared by the json string unescape block
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int unsigned CODE_W = 21;

    typedef logic [CODE_W-1:0] t_code;

    typedef enum logic [2:0] {
        E_OK     = 3'd0,
        E_ESCAPE = 3'd1,
        E_HEX    = 3'd2,
        E_BSLASH = 3'd3,
        E_NOU    = 3'd4,
        E_SURR   = 3'd5
    } t_err;

    typedef struct packed {
        logic  begin_req;
        t_code char_code;
    } t_item;

    typedef struct packed {
        logic  out_valid;
        t_code out_code;
        logic  string_end;
        t_err  error_code;
    } t_result;

    localparam t_code C_QUOTE  = 21'h22;
    localparam t_code C_BSLASH = 21'h5c;
    localparam t_code C_SLASH  = 21'h2f;
    localparam t_code C_LC_B   = 21'h62;
    localparam t_code C_LC_F   = 21'h66;
    localparam t_code C_LC_N   = 21'h6e;
    localparam t_code C_LC_R   = 21'h72;
    localparam t_code C_LC_T   = 21'h74;
    localparam t_code C_LC_U   = 21'h75;
    localparam t_code C_BS     = 21'h08;
    localparam t_code C_FF     = 21'h0c;
    localparam t_code C_LF     = 21'h0a;
    localparam t_code C_CR     = 21'h0d;
    localparam t_code C_TAB    = 21'h09;
    localparam t_code C_DIG_0  = 21'h30;
    localparam t_code C_DIG_9  = 21'h39;
    localparam t_code C_LC_A   = 21'h61;
    localparam t_code C_UC_A   = 21'h41;
    localparam t_code C_UC_F   = 21'h46;

    localparam logic [15:0] C_SURR_MASK = 16'hfc00;
    localparam logic [15:0] C_SURR_HIGH = 16'hd800;
    localparam logic [15:0] C_SURR_LOW  = 16'hdc00;
    localparam logic [9:0]  C_TEN_BITS  = 10'h3ff;
    localparam t_code       C_SUPP_BASE = 21'h10000;

    localparam logic [2:0] HEX_DIGITS = 3'd4;

endpackage

### src/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// character channel: one input character per beat
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic                 valid;
    logic                 ready;
    logic                 begin_req;
    logic [20:0]          char_code;

    modport source (output valid, output begin_req, output char_code, input ready);
    modport sink   (input valid, input begin_req, input char_code, output ready);
endinterface

### src/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// result channel: one decoded result per beat
// ----------------------------------------------------------------------------
interface jsu_out_if;
    logic                 valid;
    logic                 ready;
    logic                 out_valid;
    logic [20:0]          out_code;
    logic                 string_end;
    logic [2:0]           error_code;

    modport source (
        output valid, output out_valid, output out_code, output string_end,
        output error_code, input ready
    );
    modport sink (
        input valid, input out_valid, input out_code, input string_end,
        input error_code, output ready
    );
endinterface

### src/jsu_in_stage.sv
// ----------------------------------------------------------------------------
// jsu_in_stage
// input register holding one character beat ahead of the decoder
// ----------------------------------------------------------------------------
module jsu_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  jsu_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output jsu_pkg::t_item o_item
);
    import jsu_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end
endmodule

### src/jsu_core.sv
// ----------------------------------------------------------------------------
// jsu_core
// decoder state and the single-step unescape logic
// ----------------------------------------------------------------------------
module jsu_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  jsu_pkg::t_item   i_item,
    output jsu_pkg::t_result o_result
);
    import jsu_pkg::*;

    typedef enum logic [3:0] {
        M_PLAIN   = 4'd0,
        M_ESC     = 4'd1,
        M_HEX     = 4'd2,
        M_LO_HEX  = 4'd3,
        M_HI_HEX  = 4'd4,
        M_LO_WAIT = 4'd5,
        M_HI_WAIT = 4'd6,
        M_LO_ESC  = 4'd7,
        M_HI_ESC  = 4'd8
    } t_mode;

    function automatic logic [4:0] hex_value(input t_code c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= C_DIG_0 && c <= C_DIG_9) begin
            v = {1'b0, 4'(c - C_DIG_0)};
        end else if (c >= C_LC_A && c <= C_LC_F) begin
            v = {1'b0, 4'(c - C_LC_A + 21'd10)};
        end else if (c >= C_UC_A && c <= C_UC_F) begin
            v = {1'b0, 4'(c - C_UC_A + 21'd10)};
        end
        return v;
    endfunction

    function automatic t_code combine(input logic [15:0] lo, input logic [15:0] hi);
        return {1'b0, hi[9:0] & C_TEN_BITS, lo[9:0] & C_TEN_BITS} + C_SUPP_BASE;
    endfunction

    t_mode       r_mode, n_mode, eff_mode;
    logic [15:0] r_acc, n_acc, eff_acc, acc_new;
    logic [2:0]  r_dig, n_dig, eff_dig, dig_new;
    logic [15:0] r_first, n_first, eff_first;
    logic        r_hold, n_hold, eff_hold;
    logic [4:0]  hexd;
    t_code       c;
    t_err        err;
    t_result     res;

    assign c = i_item.char_code;

    always_comb begin
        eff_mode  = i_item.begin_req ? M_PLAIN : r_mode;
        eff_acc   = i_item.begin_req ? 16'h0   : r_acc;
        eff_dig   = i_item.begin_req ? 3'd0    : r_dig;
        eff_first = i_item.begin_req ? 16'h0   : r_first;
        eff_hold  = i_item.begin_req ? 1'b0    : r_hold;

        n_mode  = eff_mode;
        n_acc   = eff_acc;
        n_dig   = eff_dig;
        n_first = eff_first;
        n_hold  = eff_hold;

        hexd    = hex_value(c);
        acc_new = {eff_acc[11:0], hexd[3:0]};
        dig_new = eff_dig - 3'd1;
        err     = E_OK;
        res     = '0;

        if (!eff_hold) begin
            unique case (eff_mode)
                M_ESC: begin
                    n_mode = M_PLAIN;
                    priority if (c == C_QUOTE || c == C_BSLASH || c == C_SLASH) begin
                        res.out_valid = 1'b1;
                        res.out_code  = c;
                    end else if (c == C_LC_B) begin
                        res.out_valid = 1'b1;
                        res.out_code  = C_BS;
                    end else if (c == C_LC_F) begin
                        res.out_valid = 1'b1;
                        res.out_code  = C_FF;
                    end else if (c == C_LC_N) begin
                        res.out_valid = 1'b1;
                        res.out_code  = C_LF;
                    end else if (c == C_LC_R) begin
                        res.out_valid = 1'b1;
                        res.out_code  = C_CR;
                    end else if (c == C_LC_T) begin
                        res.out_valid = 1'b1;
                        res.out_code  = C_TAB;
                    end else if (c == C_LC_U) begin
                        n_acc  = 16'h0;
                        n_dig  = HEX_DIGITS;
                        n_mode = M_HEX;
                    end else begin
                        err = E_ESCAPE;
                    end
                end
                M_HEX, M_LO_HEX, M_HI_HEX: begin
                    if (hexd[4]) begin
                        err = E_HEX;
                    end else begin
                        n_acc = acc_new;
                        n_dig = dig_new;
                        if (dig_new == 3'd0) begin
                            if (eff_mode == M_HEX) begin
                                if ((acc_new & C_SURR_MASK) == C_SURR_HIGH) begin
                                    n_first = acc_new;
                                    n_mode  = M_HI_WAIT;
                                end else if ((acc_new & C_SURR_MASK) == C_SURR_LOW) begin
                                    n_first = acc_new;
                                    n_mode  = M_LO_WAIT;
                                end else begin
                                    res.out_valid = 1'b1;
                                    res.out_code  = {5'd0, acc_new};
                                    n_mode        = M_PLAIN;
                                end
                            end else if (eff_mode == M_LO_HEX) begin
                                if ((acc_new & C_SURR_MASK) != C_SURR_HIGH) begin
                                    err = E_SURR;
                                end else begin
                                    res.out_valid = 1'b1;
                                    res.out_code  = combine(eff_first, acc_new);
                                    n_mode        = M_PLAIN;
                                end
                            end else begin
                                if ((acc_new & C_SURR_MASK) != C_SURR_LOW) begin
                                    err = E_SURR;
                                end else begin
                                    res.out_valid = 1'b1;
                                    res.out_code  = combine(acc_new, eff_first);
                                    n_mode        = M_PLAIN;
                                end
                            end
                        end
                    end
                end
                M_LO_WAIT, M_HI_WAIT: begin
                    if (c != C_BSLASH) begin
                        err = E_BSLASH;
                    end else begin
                        n_mode = (eff_mode == M_LO_WAIT) ? M_LO_ESC : M_HI_ESC;
                    end
                end
                M_LO_ESC, M_HI_ESC: begin
                    if (c != C_LC_U) begin
                        err = E_NOU;
                    end else begin
                        n_acc  = 16'h0;
                        n_dig  = HEX_DIGITS;
                        n_mode = (eff_mode == M_LO_ESC) ? M_LO_HEX : M_HI_HEX;
                    end
                end
                default: begin
                    n_mode = M_PLAIN;
                    if (c == C_BSLASH) begin
                        n_mode = M_ESC;
                    end else if (c == C_QUOTE) begin
                        res.string_end = 1'b1;
                    end else begin
                        res.out_valid = 1'b1;
                        res.out_code  = c;
                    end
                end
            endcase

            if (err != E_OK) begin
                n_hold         = 1'b1;
                res            = '0;
                res.error_code = err;
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_PLAIN;
            r_acc   <= 16'h0;
            r_dig   <= 3'd0;
            r_first <= 16'h0;
            r_hold  <= 1'b0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_dig   <= n_dig;
            r_first <= n_first;
            r_hold  <= n_hold;
        end
    end
endmodule

### src/jsu_out_stage.sv
// ----------------------------------------------------------------------------
// jsu_out_stage
// result register decoupling the decoder from the result channel
// ----------------------------------------------------------------------------
module jsu_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output jsu_pkg::t_result o_result
);
    import jsu_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end
endmodule

### src/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top
// path: input register, then combinational decoder, then result register
// throughput: one character per cycle unless stalled, set by the state loop
// synchronous active-low reset empties both registers and returns to plain text
// ----------------------------------------------------------------------------
module json_string_unescape_top (
    input  logic   i_clk,
    input  logic   i_rst_n,
    jsu_in_if.sink i_in,
    jsu_out_if.source o_out
);
    import jsu_pkg::*;

    t_item   in_item, st_item;
    t_result core_res, out_res;
    logic    st_valid, out_free, step;

    assign in_item.begin_req = i_in.begin_req;
    assign in_item.char_code = i_in.char_code;
    assign step              = st_valid && out_free;

    jsu_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (st_valid),
        .o_item  (st_item)
    );

    jsu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (st_item),
        .o_result (core_res)
    );

    jsu_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_res),
        .o_free   (out_free),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (out_res)
    );

    assign o_out.out_valid  = out_res.out_valid;
    assign o_out.out_code   = out_res.out_code;
    assign o_out.string_end = out_res.string_end;
    assign o_out.error_code = out_res.error_code;

`ifndef SYNTH
    a_err_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error_code != E_OK) |-> (!o_out.out_valid && !o_out.string_end))
        else $error("error beat carries a code point or string end");

    a_end_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.string_end) |-> !o_out.out_valid)
        else $error("string end beat carries a code point");

    a_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.out_valid) |-> (o_out.out_code == '0))
        else $error("code set without out_valid");
`endif
endmodule

### verif/json_string_unescape_top_tb.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top_tb
// self-checking bench for the json string body decoder: characters are sent
// one beat at a time with random gaps, each accepted character is run through
// a local decoder model, and every result beat is compared field by field
// ----------------------------------------------------------------------------
module json_string_unescape_top_tb;

    import jsu_pkg::*;

    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef enum logic [3:0] {
        MD_PLAIN,
        MD_ESC,
        MD_HEX,
        MD_LO_HEX,
        MD_HI_HEX,
        MD_LO_WAIT,
        MD_HI_WAIT,
        MD_LO_ESC,
        MD_HI_ESC
    } t_dec_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_dec_mode   dec_mode;
    logic [15:0] dec_accum;
    logic [2:0]  dec_left;
    logic [15:0] dec_first;
    logic        dec_hold;

    t_result     pending_results [$];
    int unsigned items_sent;
    int unsigned fail_count;
    int unsigned stall_cycles;
    logic        begin_next;
    logic        no_idle;
    logic        rx_hold_req;

    function automatic logic [4:0] hex_val(input t_code c);
        if (c >= C_DIG_0 && c <= C_DIG_9) return 5'(c - C_DIG_0);
        if (c >= C_LC_A && c <= C_LC_F) return 5'(c - C_LC_A + 10);
        if (c >= C_UC_A && c <= C_UC_F) return 5'(c - C_UC_A + 10);
        return 5'd16;
    endfunction

    function automatic t_code pair_code(input logic [15:0] lo, input logic [15:0] hi);
        return t_code'({hi[9:0] & C_TEN_BITS, lo[9:0] & C_TEN_BITS}) + C_SUPP_BASE;
    endfunction

    function automatic t_result decode_char(input logic bgn, input t_code c);
        t_result    r;
        logic [4:0] d;
        r = '0;
        r.error_code = E_OK;
        if (bgn) begin
            dec_mode  = MD_PLAIN;
            dec_accum = '0;
            dec_left  = '0;
            dec_first = '0;
            dec_hold  = 1'b0;
        end
        if (!dec_hold) begin
            case (dec_mode)
                MD_ESC: begin
                    dec_mode = MD_PLAIN;
                    if (c == C_QUOTE || c == C_BSLASH || c == C_SLASH) begin
                        r.out_valid = 1'b1;
                        r.out_code  = c;
                    end else if (c == C_LC_B) begin
                        r.out_valid = 1'b1;
                        r.out_code  = C_BS;
                    end else if (c == C_LC_F) begin
                        r.out_valid = 1'b1;
                        r.out_code  = C_FF;
                    end else if (c == C_LC_N) begin
                        r.out_valid = 1'b1;
                        r.out_code  = C_LF;
                    end else if (c == C_LC_R) begin
                        r.out_valid = 1'b1;
                        r.out_code  = C_CR;
                    end else if (c == C_LC_T) begin
                        r.out_valid = 1'b1;
                        r.out_code  = C_TAB;
                    end else if (c == C_LC_U) begin
                        dec_accum = '0;
                        dec_left  = HEX_DIGITS;
                        dec_mode  = MD_HEX;
                    end else begin
                        r.error_code = E_ESCAPE;
                    end
                end
                MD_HEX, MD_LO_HEX, MD_HI_HEX: begin
                    d = hex_val(c);
                    if (d[4]) begin
                        r.error_code = E_HEX;
                    end else begin
                        dec_accum = {dec_accum[11:0], d[3:0]};
                        dec_left  = dec_left - 3'd1;
                        if (dec_left == 3'd0) begin
                            if (dec_mode == MD_HEX) begin
                                if ((dec_accum & C_SURR_MASK) == C_SURR_HIGH) begin
                                    dec_first = dec_accum;
                                    dec_mode  = MD_HI_WAIT;
                                end else if ((dec_accum & C_SURR_MASK) == C_SURR_LOW) begin
                                    dec_first = dec_accum;
                                    dec_mode  = MD_LO_WAIT;
                                end else begin
                                    r.out_valid = 1'b1;
                                    r.out_code  = t_code'(dec_accum);
                                    dec_mode    = MD_PLAIN;
                                end
                            end else if (dec_mode == MD_LO_HEX) begin
                                if ((dec_accum & C_SURR_MASK) != C_SURR_HIGH) begin
                                    r.error_code = E_SURR;
                                end else begin
                                    r.out_valid = 1'b1;
                                    r.out_code  = pair_code(dec_first, dec_accum);
                                    dec_mode    = MD_PLAIN;
                                end
                            end else begin
                                if ((dec_accum & C_SURR_MASK) != C_SURR_LOW) begin
                                    r.error_code = E_SURR;
                                end else begin
                                    r.out_valid = 1'b1;
                                    r.out_code  = pair_code(dec_accum, dec_first);
                                    dec_mode    = MD_PLAIN;
                                end
                            end
                        end
                    end
                end
                MD_LO_WAIT, MD_HI_WAIT: begin
                    if (c != C_BSLASH) r.error_code = E_BSLASH;
                    else dec_mode = (dec_mode == MD_LO_WAIT) ? MD_LO_ESC : MD_HI_ESC;
                end
                MD_LO_ESC, MD_HI_ESC: begin
                    if (c != C_LC_U) begin
                        r.error_code = E_NOU;
                    end else begin
                        dec_accum = '0;
                        dec_left  = HEX_DIGITS;
                        dec_mode  = (dec_mode == MD_LO_ESC) ? MD_LO_HEX : MD_HI_HEX;
                    end
                end
                default: begin
                    dec_mode = MD_PLAIN;
                    if (c == C_BSLASH) begin
                        dec_mode = MD_ESC;
                    end else if (c == C_QUOTE) begin
                        r.string_end = 1'b1;
                    end else begin
                        r.out_valid = 1'b1;
                        r.out_code  = c;
                    end
                end
            endcase
            if (r.error_code != E_OK) begin
                dec_hold     = 1'b1;
                r.out_valid  = 1'b0;
                r.out_code   = '0;
                r.string_end = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic t_code hex_char(input logic [3:0] n);
        if (n < 4'd10) return C_DIG_0 + t_code'(n);
        if ($urandom_range(0, 1) == 0) return C_LC_A + t_code'(n - 4'd10);
        return C_UC_A + t_code'(n - 4'd10);
    endfunction

    function automatic t_code rand_any();
        if ($urandom_range(0, 1) == 0) return t_code'($urandom_range(0, 127));
        return t_code'($urandom_range(0, 21'h10ffff));
    endfunction

    function automatic t_code rand_plain();
        t_code c;
        do begin
            if ($urandom_range(0, 1) == 0) c = t_code'($urandom_range(32, 126));
            else c = t_code'($urandom_range(0, 21'h10ffff));
        end while (c == C_QUOTE || c == C_BSLASH);
        return c;
    endfunction

    function automatic logic is_escape_letter(input t_code c);
        return c == C_QUOTE || c == C_BSLASH || c == C_SLASH || c == C_LC_B ||
               c == C_LC_F || c == C_LC_N || c == C_LC_R || c == C_LC_T || c == C_LC_U;
    endfunction

    function automatic t_code escape_letter(input int unsigned idx);
        case (idx)
            0: return C_QUOTE;
            1: return C_BSLASH;
            2: return C_SLASH;
            3: return C_LC_B;
            4: return C_LC_F;
            5: return C_LC_N;
            6: return C_LC_R;
            default: return C_LC_T;
        endcase
    endfunction

    function automatic logic [15:0] rand_surrogate(input logic high);
        logic [15:0] v;
        v = 16'($urandom_range(0, 16'h3ff));
        return (high ? C_SURR_HIGH : C_SURR_LOW) | v;
    endfunction

    task automatic send_char(input t_code c);
        int unsigned gap;
        logic        bgn;
        bgn = begin_next;
        begin_next = 1'b0;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.begin_req <= bgn;
        in_ch.char_code <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(decode_char(bgn, c));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_u16(input logic [15:0] v);
        send_char(C_BSLASH);
        send_char(C_LC_U);
        send_char(hex_char(v[15:12]));
        send_char(hex_char(v[11:8]));
        send_char(hex_char(v[7:4]));
        send_char(hex_char(v[3:0]));
    endtask

    task automatic random_segment();
        int unsigned kind;
        int unsigned n;
        logic        high;
        logic [15:0] v;
        logic [15:0] w;
        t_code       c;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 15) == 0) begin_next = 1'b1;
        if (kind < 30) begin
            send_char(rand_plain());
        end else if (kind < 45) begin
            send_char(C_BSLASH);
            send_char(escape_letter($urandom_range(0, 7)));
        end else if (kind < 60) begin
            do v = 16'($urandom);
            while ((v & C_SURR_MASK) == C_SURR_HIGH || (v & C_SURR_MASK) == C_SURR_LOW);
            send_u16(v);
        end else if (kind < 72) begin
            v = rand_surrogate(1'b1);
            w = rand_surrogate(1'b0);
            if ($urandom_range(0, 1) == 0) begin
                send_u16(v);
                send_u16(w);
            end else begin
                send_u16(w);
                send_u16(v);
            end
        end else if (kind < 78) begin
            send_char(C_QUOTE);
        end else if (kind < 92) begin
            high = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                0: begin
                    send_char(C_BSLASH);
                    do c = rand_any(); while (is_escape_letter(c));
                    send_char(c);
                end
                1: begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_u16(rand_surrogate(high));
                        send_char(C_BSLASH);
                    end else begin
                        send_char(C_BSLASH);
                    end
                    send_char(C_LC_U);
                    repeat ($urandom_range(0, 3)) send_char(hex_char(4'($urandom)));
                    do c = rand_any(); while (hex_val(c) < 5'd16);
                    send_char(c);
                end
                2: begin
                    send_u16(rand_surrogate(high));
                    do c = rand_any(); while (c == C_BSLASH);
                    send_char(c);
                end
                3: begin
                    send_u16(rand_surrogate(high));
                    send_char(C_BSLASH);
                    do c = rand_any(); while (c == C_LC_U);
                    send_char(c);
                end
                default: begin
                    send_u16(rand_surrogate(high));
                    do w = 16'($urandom);
                    while ((w & C_SURR_MASK) == (high ? C_SURR_LOW : C_SURR_HIGH));
                    send_u16(w);
                end
            endcase
            repeat ($urandom_range(0, 2)) send_char(rand_any());
            begin_next = 1'b1;
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                begin_next = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 4))
                    0: send_char(C_BSLASH);
                    1: send_char(C_QUOTE);
                    2: send_char(C_LC_U);
                    3: send_char(hex_char(4'($urandom)));
                    default: send_char(rand_any());
                endcase
            end
        end
    endtask

    task automatic test_plain_extremes();
        begin_next = 1'b1;
        send_char(21'h10ffff);
        send_char(21'h000000);
    endtask

    task automatic test_escapes_and_end();
        send_char(C_BSLASH);
        send_char(C_LC_B);
        send_char(C_BSLASH);
        send_char(C_QUOTE);
        send_char(C_QUOTE);
        send_char(C_UC_A);
    endtask

    task automatic test_surrogate_extremes();
        send_u16(16'hdbff);
        send_u16(16'hdc00);
    endtask

    task automatic test_error_hold();
        send_char(C_BSLASH);
        send_char(21'h78);
        send_char(C_UC_A);
        begin_next = 1'b1;
        send_char(C_UC_F);
    endtask

    task automatic test_random_mix(input int unsigned target);
        while (items_sent < target) random_segment();
    endtask

    task automatic test_full_rate();
        int unsigned stop_at;
        stop_at = items_sent + 150;
        no_idle = 1'b1;
        while (items_sent < stop_at) random_segment();
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        begin_next  = 1'b1;
        rx_hold_req = 1'b1;
        no_idle     = 1'b1;
        repeat (40) send_char(rand_plain());
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (20) random_segment();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) random_segment();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.begin_req = 1'b0;
        in_ch.char_code = '0;
        dec_mode        = MD_PLAIN;
        dec_accum       = '0;
        dec_left        = '0;
        dec_first       = '0;
        dec_hold        = 1'b0;
        items_sent      = 0;
        fail_count      = 0;
        begin_next      = 1'b0;
        no_idle         = 1'b0;
        rx_hold_req     = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_extremes();
        test_escapes_and_end();
        test_surrogate_extremes();
        test_error_hold();
        test_random_mix(800);
        test_full_rate();
        test_backpressure();
        test_drain_pause();
        test_random_mix(1900);

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("json_string_unescape_top verification clean");
        end else begin
            $display("json_string_unescape_top verification failed");
        end
        $finish;
    end

    // result side: random ready gaps, one long hold on request
    initial begin
        int unsigned gap;
        t_result     exp_r;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (rx_hold_req) begin
                gap = gap + RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result beat: valid=%0d code=%h end=%0d err=%0d",
                             out_ch.out_valid, out_ch.out_code, out_ch.string_end,
                             out_ch.error_code);
            end else begin
                exp_r = pending_results.pop_front();
                if (out_ch.out_valid !== exp_r.out_valid ||
                    out_ch.out_code !== exp_r.out_code ||
                    out_ch.string_end !== exp_r.string_end ||
                    out_ch.error_code !== exp_r.error_code) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: exp valid=%0d code=%h end=%0d err=%0d",
                                 exp_r.out_valid, exp_r.out_code, exp_r.string_end,
                                 exp_r.error_code);
                        $display("          got valid=%0d code=%h end=%0d err=%0d",
                                 out_ch.out_valid, out_ch.out_code, out_ch.string_end,
                                 out_ch.error_code);
                    end
                end
            end
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("json_string_unescape_top verification failed");
                $finish;
            end
        end
    end

endmodule
